// ===== src/mt19937_random_generator_assert.svh =====
// Assertion macros shared by the generator RTL.
`ifndef MT19937_RANDOM_GENERATOR_ASSERT_SVH
`define MT19937_RANDOM_GENERATOR_ASSERT_SVH

// Implication checked at every clock edge, off during reset.
`define MTRG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal must stay low at every clock edge, off during reset.
`define MTRG_ASSERT_NEVER(label, clk, rst_n, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(sig)) else $error(msg);

`endif

// ===== src/mtrg_pkg.sv =====
// Shared types and constants of the MT19937 generator.
package mtrg_pkg;

  localparam int unsigned WORD_W             = 32;
  localparam int unsigned MTRG_STATE_WORDS   = 624;
  localparam int unsigned MTRG_MIDDLE_OFFSET = 397;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t SEED_MULT    = 32'd1812433253;
  localparam word_t DEFAULT_SEED = 32'd5489;
  localparam word_t TWIST_MATRIX = 32'h9908b0df;
  localparam word_t UPPER_BIT    = 32'h80000000;
  localparam word_t LOWER_BITS   = 32'h7fffffff;
  localparam word_t TEMPER_B     = 32'h9d2c5680;
  localparam word_t TEMPER_C     = 32'hefc60000;
  localparam int unsigned SEED_SHIFT = 30;

  // request kinds
  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_SEED = 1'b1;

endpackage

// ===== src/mt19937_random_generator.sv =====
// Top level of the MT19937 generator: control, seeding and the state chain.
//
// A draw request is taken in idle and busy_o stays low, so draws may be
// issued every cycle; the masked word appears on random_word_o with done_o
// high for one cycle, the cycle after the request. The receiver cannot
// stall it. A seed request holds busy_o high once it is taken, while
// the seed recurrence, a 32x32 multiply-add, pushes one word per
// cycle into the 624-cell state chain. A draw issued before any seed first
// seeds with 5489 and holds busy_o high while seeding, then gives its word.
// Each draw twists the head word of the chain on the fly and shifts it
// back in at the tail. The state needs no clearing pass after reset.
module mt19937_random_generator
  import mtrg_pkg::*;
#(
  parameter int unsigned STATE_WORDS   = MTRG_STATE_WORDS,
  parameter int unsigned MIDDLE_OFFSET = MTRG_MIDDLE_OFFSET
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output logic  busy_o,
  input  logic  kind_i,
  input  word_t seed_i,
  input  word_t mask_i,
  output word_t random_word_o,
  output logic  done_o
);

  `include "mt19937_random_generator_assert.svh"

  localparam int unsigned CNT_W = $clog2(STATE_WORDS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STATE_WORDS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SEED  = 2'd1;
  localparam logic [1:0] ST_DRAWP = 2'd2;

  function automatic word_t seed_next(input word_t prev, input logic [CNT_W-1:0] idx);
    word_t mixed;
    mixed = prev ^ (prev >> SEED_SHIFT);
    return word_t'(SEED_MULT * mixed) + {{(WORD_W-CNT_W){1'b0}}, idx};
  endfunction

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             seeded_q, seeded_d;
  logic             mask_pending_q;
  word_t            mask_q;

  logic  accept;
  logic  seed_start;
  logic  draw_go;
  logic  shift;
  word_t push_word;
  word_t draw_mask;
  word_t twisted;
  word_t cell_q [STATE_WORDS];

  assign accept     = start_i && (state_q == ST_IDLE);
  assign seed_start = accept && ((kind_i == KIND_SEED) || !seeded_q);
  assign draw_go    = (accept && (kind_i == KIND_DRAW) && seeded_q) ||
                      (state_q == ST_DRAWP);
  assign shift      = draw_go || seed_start || (state_q == ST_SEED);
  assign draw_mask  = (state_q == ST_DRAWP) ? mask_q : mask_i;
  assign busy_o     = (state_q != ST_IDLE);

  always_comb begin
    if (draw_go) begin
      push_word = twisted;
    end else if (seed_start) begin
      push_word = (kind_i == KIND_SEED) ? seed_i : DEFAULT_SEED;
    end else begin
      push_word = seed_next(cell_q[STATE_WORDS-1], cnt_q);
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    seeded_d = seeded_q;
    case (state_q)
      ST_IDLE: begin
        if (seed_start) begin
          state_d  = ST_SEED;
          cnt_d    = CNT_W'(1);
          seeded_d = 1'b1;
        end
      end
      ST_SEED: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          // finish a draw that came before any seed
          state_d = mask_pending_q ? ST_DRAWP : ST_IDLE;
        end
      end
      ST_DRAWP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      seeded_q       <= 1'b0;
      mask_pending_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      seeded_q <= seeded_d;
      if (seed_start) begin
        mask_pending_q <= (kind_i == KIND_DRAW);
      end else if (state_q == ST_DRAWP) begin
        mask_pending_q <= 1'b0;
      end
    end
  end

  // hold the mask of a draw that waits for default seeding
  always_ff @(posedge clk_i) begin
    if (seed_start) begin
      mask_q <= mask_i;
    end
  end

  for (genvar i = 0; i < STATE_WORDS; i++) begin : g_cell
    if (i == STATE_WORDS - 1) begin : g_tail
      mtrg_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(shift),
        .word_i (push_word),
        .word_o (cell_q[i])
      );
    end else begin : g_body
      mtrg_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(shift),
        .word_i (cell_q[i+1]),
        .word_o (cell_q[i])
      );
    end
  end

  mtrg_twist u_twist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (draw_go),
    .head_i       (cell_q[0]),
    .next_i       (cell_q[1]),
    .far_i        (cell_q[MIDDLE_OFFSET]),
    .mask_i       (draw_mask),
    .new_word_o   (twisted),
    .random_word_o(random_word_o),
    .done_o       (done_o)
  );

  `MTRG_ASSERT(a_seed_busy, clk_i, rst_ni, (start_i && !busy_o && (kind_i == KIND_SEED)) |=> busy_o, "seed request did not raise busy")
  `MTRG_ASSERT(a_seed_hold, clk_i, rst_ni, (state_q == ST_SEED && cnt_q != CNT_LAST) |=> (state_q == ST_SEED), "seeding cut short")
  `MTRG_ASSERT_NEVER(a_no_result_seeding, clk_i, rst_ni, (state_q == ST_SEED) && done_o, "result during seeding")
  `MTRG_ASSERT(a_pending_draw, clk_i, rst_ni, (state_q == ST_DRAWP) |=> done_o, "pending draw gave no result")

endmodule

// ===== src/mtrg_cell.sv =====
// One word of the twister state chain.
module mtrg_cell
  import mtrg_pkg::*;
(
  input  logic  clk_i,
  input  logic  shift_i,
  input  word_t word_i,
  output word_t word_o
);

  word_t word_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      word_q <= word_i;
    end
  end

  assign word_o = word_q;

endmodule

// ===== src/mtrg_twist.sv =====
// Twist of the head word and tempered, masked output register.
module mtrg_twist
  import mtrg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,
  input  word_t head_i,
  input  word_t next_i,
  input  word_t far_i,
  input  word_t mask_i,
  output word_t new_word_o,
  output word_t random_word_o,
  output logic  done_o
);

  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  word_t mix;
  word_t random_word_q;
  logic  done_q;

  always_comb begin
    mix        = (head_i & UPPER_BIT) | (next_i & LOWER_BITS);
    new_word_o = far_i ^ (mix >> 1) ^ (mix[0] ? TWIST_MATRIX : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fire_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      random_word_q <= temper(new_word_o) & mask_i;
    end
  end

  assign random_word_o = random_word_q;
  assign done_o        = done_q;

endmodule
